// ----- rtl/srht_pkg.sv -----
// Shared types for the segment and rectangle hit test pipeline.
package srht_pkg;

	// Per-item flags that travel down the pipeline next to the products.
	typedef struct packed {
		logic str_bottom; // bottom edge line lies between the segment's endpoints
		logic str_top;
		logic str_left;
		logic str_right;
		logic w_nz;       // rectangle has nonzero width
		logic h_nz;       // rectangle has nonzero height
		logic dx_nz;      // segment is not vertical
		logic dy_nz;      // segment is not horizontal
	} srht_flags_t;

endpackage

// ----- rtl/srht_ifs.sv -----
// Request and response channel interfaces of the hit test unit.
interface srht_req_if #(parameter int COORD_BITS = 16) ();
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] rect_left;
	logic signed [COORD_BITS-1:0] rect_top;
	logic [COORD_BITS-2:0] rect_width;
	logic [COORD_BITS-2:0] rect_height;
	logic signed [COORD_BITS-1:0] seg_start_x;
	logic signed [COORD_BITS-1:0] seg_start_y;
	logic signed [COORD_BITS-1:0] seg_end_x;
	logic signed [COORD_BITS-1:0] seg_end_y;

	modport source (
		output valid, rect_left, rect_top, rect_width, rect_height,
		output seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		input ready
	);
	modport sink (
		input valid, rect_left, rect_top, rect_width, rect_height,
		input seg_start_x, seg_start_y, seg_end_x, seg_end_y,
		output ready
	);
endinterface

interface srht_rsp_if ();
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

// ----- rtl/srht_diff.sv -----
// First stage: coordinate differences relative to the segment start and edge range flags.
module srht_diff import srht_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic v_in,
	output logic ready_up,
	input  logic ready_dn,
	output logic v_out,
	input  logic signed [COORD_BITS-1:0] rect_left,
	input  logic signed [COORD_BITS-1:0] rect_top,
	input  logic [COORD_BITS-2:0] rect_width,
	input  logic [COORD_BITS-2:0] rect_height,
	input  logic signed [COORD_BITS-1:0] seg_start_x,
	input  logic signed [COORD_BITS-1:0] seg_start_y,
	input  logic signed [COORD_BITS-1:0] seg_end_x,
	input  logic signed [COORD_BITS-1:0] seg_end_y,
	output logic signed [COORD_BITS+1:0] dx,
	output logic signed [COORD_BITS+1:0] dy,
	output logic signed [COORD_BITS+1:0] exl,
	output logic signed [COORD_BITS+1:0] exr,
	output logic signed [COORD_BITS+1:0] eyt,
	output logic signed [COORD_BITS+1:0] eyb,
	output srht_flags_t flags
);
	localparam int DW = COORD_BITS + 2;

	logic signed [DW-1:0] left_e, top_e, right_e, bottom_e;
	logic signed [DW-1:0] x1_e, y1_e, x2_e, y2_e;
	srht_flags_t flags_d;

	logic v_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, exl_s1, exr_s1, eyt_s1, eyb_s1;
	srht_flags_t flags_s1;

	assign left_e   = DW'(rect_left);
	assign top_e    = DW'(rect_top);
	assign right_e  = left_e + DW'(rect_width);
	assign bottom_e = top_e + DW'(rect_height);
	assign x1_e     = DW'(seg_start_x);
	assign y1_e     = DW'(seg_start_y);
	assign x2_e     = DW'(seg_end_x);
	assign y2_e     = DW'(seg_end_y);

	// An edge's line separates or touches the endpoints when it lies between them.
	always_comb begin
		flags_d.str_bottom = (y1_e <= bottom_e && y2_e >= bottom_e) ||
			(y1_e >= bottom_e && y2_e <= bottom_e);
		flags_d.str_top = (y1_e <= top_e && y2_e >= top_e) ||
			(y1_e >= top_e && y2_e <= top_e);
		flags_d.str_left = (x1_e <= left_e && x2_e >= left_e) ||
			(x1_e >= left_e && x2_e <= left_e);
		flags_d.str_right = (x1_e <= right_e && x2_e >= right_e) ||
			(x1_e >= right_e && x2_e <= right_e);
		flags_d.w_nz  = |rect_width;
		flags_d.h_nz  = |rect_height;
		flags_d.dx_nz = seg_start_x != seg_end_x;
		flags_d.dy_nz = seg_start_y != seg_end_y;
	end

	assign ready_up = !v_s1 || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ready_up) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (v_in && ready_up) begin
			dx_s1    <= x2_e - x1_e;
			dy_s1    <= y2_e - y1_e;
			exl_s1   <= left_e - x1_e;
			exr_s1   <= right_e - x1_e;
			eyt_s1   <= top_e - y1_e;
			eyb_s1   <= bottom_e - y1_e;
			flags_s1 <= flags_d;
		end
	end

	assign v_out = v_s1;
	assign dx    = dx_s1;
	assign dy    = dy_s1;
	assign exl   = exl_s1;
	assign exr   = exr_s1;
	assign eyt   = eyt_s1;
	assign eyb   = eyb_s1;
	assign flags = flags_s1;
endmodule

// ----- rtl/srht_mul.sv -----
// Second stage: the four cross-product terms shared by the rectangle corners.
module srht_mul import srht_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic v_in,
	output logic ready_up,
	input  logic ready_dn,
	output logic v_out,
	input  logic signed [COORD_BITS+1:0] dx,
	input  logic signed [COORD_BITS+1:0] dy,
	input  logic signed [COORD_BITS+1:0] exl,
	input  logic signed [COORD_BITS+1:0] exr,
	input  logic signed [COORD_BITS+1:0] eyt,
	input  logic signed [COORD_BITS+1:0] eyb,
	input  srht_flags_t flags_in,
	output logic signed [2*COORD_BITS+3:0] al,
	output logic signed [2*COORD_BITS+3:0] ar,
	output logic signed [2*COORD_BITS+3:0] bt,
	output logic signed [2*COORD_BITS+3:0] bb,
	output srht_flags_t flags
);
	localparam int PW = 2 * COORD_BITS + 4;

	logic v_s2;
	logic signed [PW-1:0] al_s2, ar_s2, bt_s2, bb_s2;
	srht_flags_t flags_s2;

	assign ready_up = !v_s2 || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ready_up) begin
			v_s2 <= v_in;
		end
	end

	// Corner value is dy*(x - x1) - dx*(y - y1); the x and y terms are shared.
	always_ff @(posedge clk) begin
		if (v_in && ready_up) begin
			al_s2    <= PW'(dy) * PW'(exl);
			ar_s2    <= PW'(dy) * PW'(exr);
			bt_s2    <= PW'(dx) * PW'(eyt);
			bb_s2    <= PW'(dx) * PW'(eyb);
			flags_s2 <= flags_in;
		end
	end

	assign v_out = v_s2;
	assign al    = al_s2;
	assign ar    = ar_s2;
	assign bt    = bt_s2;
	assign bb    = bb_s2;
	assign flags = flags_s2;
endmodule

// ----- rtl/srht_eval.sv -----
// Third stage: corner side tests, per-edge decisions and the result register.
module srht_eval import srht_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic v_in,
	output logic ready_up,
	input  logic ready_dn,
	output logic v_out,
	input  logic signed [2*COORD_BITS+3:0] al,
	input  logic signed [2*COORD_BITS+3:0] ar,
	input  logic signed [2*COORD_BITS+3:0] bt,
	input  logic signed [2*COORD_BITS+3:0] bb,
	input  srht_flags_t flags_in,
	output logic hit
);
	localparam int PW = 2 * COORD_BITS + 4;

	logic signed [PW:0] s_lt, s_lb, s_rt, s_rb;
	logic e_bottom, e_top, e_left, e_right;
	logic v_s3;
	logic hit_s3;

	function automatic logic opp_or_zero(input logic signed [PW:0] p, input logic signed [PW:0] q);
		return (p == '0) || (q == '0) || (p[PW] != q[PW]);
	endfunction

	assign s_lt = (PW+1)'(al) - (PW+1)'(bt);
	assign s_lb = (PW+1)'(al) - (PW+1)'(bb);
	assign s_rt = (PW+1)'(ar) - (PW+1)'(bt);
	assign s_rb = (PW+1)'(ar) - (PW+1)'(bb);

	// A zero-length edge or a segment parallel to the edge never counts as a hit.
	always_comb begin
		e_bottom = opp_or_zero(s_lb, s_rb) && flags_in.str_bottom &&
			flags_in.w_nz && flags_in.dy_nz;
		e_top = opp_or_zero(s_lt, s_rt) && flags_in.str_top &&
			flags_in.w_nz && flags_in.dy_nz;
		e_left = opp_or_zero(s_lt, s_lb) && flags_in.str_left &&
			flags_in.h_nz && flags_in.dx_nz;
		e_right = opp_or_zero(s_rt, s_rb) && flags_in.str_right &&
			flags_in.h_nz && flags_in.dx_nz;
	end

	assign ready_up = !v_s3 || ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ready_up) begin
			v_s3 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (v_in && ready_up) begin
			hit_s3 <= e_bottom || e_top || e_left || e_right;
		end
	end

	assign v_out = v_s3;
	assign hit   = hit_s3;
endmodule

// ----- rtl/segment_rect_hit_test_unit.sv -----
// Top level of the segment and rectangle hit test pipeline.
//
//  channel  direction  payload                                    transfer when
//  req      in         rectangle (left, top, width, height),      req.valid && req.ready
//                      segment (start x/y, end x/y)
//  rsp      out        hit                                        rsp.valid && rsp.ready
//
// Three register stages: differences, products, then side tests and the result register.
// One request per cycle is taken while rsp is not stalled.
// Each stage holds its own valid bit, so bubbles are squeezed out while rsp is stalled.
// Reset clears only the valid bits; the block keeps no state between requests.
module segment_rect_hit_test_unit import srht_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	srht_req_if.sink req,
	srht_rsp_if.source rsp
);
	localparam int DW = COORD_BITS + 2;
	localparam int PW = 2 * DW;

	logic v1, v2, v3;
	logic rdy1, rdy2, rdy3;
	logic signed [DW-1:0] dx, dy, exl, exr, eyt, eyb;
	logic signed [PW-1:0] al, ar, bt, bb;
	srht_flags_t flags1, flags2;
	logic hit;

	srht_diff #(.COORD_BITS(COORD_BITS)) u_diff (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_in        (req.valid),
		.ready_up    (rdy1),
		.ready_dn    (rdy2),
		.v_out       (v1),
		.rect_left   (req.rect_left),
		.rect_top    (req.rect_top),
		.rect_width  (req.rect_width),
		.rect_height (req.rect_height),
		.seg_start_x (req.seg_start_x),
		.seg_start_y (req.seg_start_y),
		.seg_end_x   (req.seg_end_x),
		.seg_end_y   (req.seg_end_y),
		.dx          (dx),
		.dy          (dy),
		.exl         (exl),
		.exr         (exr),
		.eyt         (eyt),
		.eyb         (eyb),
		.flags       (flags1)
	);

	srht_mul #(.COORD_BITS(COORD_BITS)) u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_in     (v1),
		.ready_up (rdy2),
		.ready_dn (rdy3),
		.v_out    (v2),
		.dx       (dx),
		.dy       (dy),
		.exl      (exl),
		.exr      (exr),
		.eyt      (eyt),
		.eyb      (eyb),
		.flags_in (flags1),
		.al       (al),
		.ar       (ar),
		.bt       (bt),
		.bb       (bb),
		.flags    (flags2)
	);

	srht_eval #(.COORD_BITS(COORD_BITS)) u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.v_in     (v2),
		.ready_up (rdy3),
		.ready_dn (rsp.ready),
		.v_out    (v3),
		.al       (al),
		.ar       (ar),
		.bt       (bt),
		.bb       (bb),
		.flags_in (flags2),
		.hit      (hit)
	);

	assign req.ready = rdy1;
	assign rsp.valid = v3;
	assign rsp.hit   = hit;
endmodule

// ----- rtl/srht_checker.sv -----
// Port-level assertions for the hit test unit and the bind that attaches them.
module srht_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic hit
);
	// A stalled result keeps its value until its transfer.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit))
		else $error("rsp payload changed while stalled");

	// A result only goes away through a transfer.
	a_rsp_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rsp_valid) |-> $past(rsp_ready))
		else $error("rsp valid dropped without a transfer");

	// With the output stage empty, every stage can advance, so requests are taken.
	a_req_open: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("req stalled while pipeline output is empty");

	// A request reaches the output when rsp does not stall while it passes through the pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
		else $error("request did not reach rsp in three cycles");
endmodule

bind segment_rect_hit_test_unit srht_checker u_srht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.hit       (rsp.hit)
);

// ----- tb/tb_segment_rect_hit_test_unit.sv -----
// Self-checking testbench for the segment and rectangle hit test unit.
`timescale 1ns / 1ps

module tb_segment_rect_hit_test_unit;

	localparam int CB = 16;
	localparam int MIN_COORD = -32768;
	localparam int MAX_COORD = 32767;
	localparam int MAX_SIZE = 32767;
	localparam int QUERIES_PER_PHASE = 150;
	localparam int LONG_HOLD_CYCLES = 120;
	localparam int DRAIN_CYCLES = 10;
	localparam int REPORT_LIMIT = 10;
	localparam longint LIMIT_NS = 2_000_000;

	typedef struct {
		logic signed [CB-1:0] rect_left;
		logic signed [CB-1:0] rect_top;
		logic [CB-2:0] rect_width;
		logic [CB-2:0] rect_height;
		logic signed [CB-1:0] seg_start_x;
		logic signed [CB-1:0] seg_start_y;
		logic signed [CB-1:0] seg_end_x;
		logic signed [CB-1:0] seg_end_y;
	} hit_query_t;

	typedef struct {
		hit_query_t query;
		bit hit;
	} expected_hit_t;

	class hit_scoreboard;
		expected_hit_t pending_hits[$];
		int failures;

		// Rejects only when both values are nonzero and share a sign.
		function bit straddles(longint p, longint q);
			return p == 0 || q == 0 || ((p < 0) != (q < 0));
		endfunction

		function bit edge_crossed(longint x1, longint y1, longint x2, longint y2,
				longint x3, longint y3, longint x4, longint y4);
			longint a1, b1, c1, a2, b2, c2;
			a1 = y2 - y1;
			b1 = x1 - x2;
			c1 = x2 * y1 - x1 * y2;
			a2 = y4 - y3;
			b2 = x3 - x4;
			c2 = x4 * y3 - x3 * y4;
			if (!straddles(a1 * x3 + b1 * y3 + c1, a1 * x4 + b1 * y4 + c1))
				return 1'b0;
			if (!straddles(a2 * x1 + b2 * y1 + c2, a2 * x2 + b2 * y2 + c2))
				return 1'b0;
			// Parallel and collinear edges never count as a crossing.
			return (a1 * b2 - a2 * b1) != 0;
		endfunction

		function bit crossing_hit(hit_query_t q);
			longint left, top, right, bottom, x1, y1, x2, y2;
			left = q.rect_left;
			top = q.rect_top;
			right = left + longint'(q.rect_width);
			bottom = top + longint'(q.rect_height);
			x1 = q.seg_start_x;
			y1 = q.seg_start_y;
			x2 = q.seg_end_x;
			y2 = q.seg_end_y;
			return edge_crossed(x1, y1, x2, y2, left, bottom, right, bottom)
				|| edge_crossed(x1, y1, x2, y2, left, top, left, bottom)
				|| edge_crossed(x1, y1, x2, y2, right, top, right, bottom)
				|| edge_crossed(x1, y1, x2, y2, left, top, right, top);
		endfunction

		function void note_query(hit_query_t q);
			expected_hit_t e;
			e.query = q;
			e.hit = crossing_hit(q);
			pending_hits.push_back(e);
		endfunction

		function void check_hit(logic hit);
			expected_hit_t e;
			if (pending_hits.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: hit=%b arrived with no query outstanding", $time, hit);
				return;
			end
			e = pending_hits.pop_front();
			if (hit !== e.hit) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("%0t: rect (%0d,%0d,%0d,%0d) seg (%0d,%0d)-(%0d,%0d): expected %b, got %b",
						$time, e.query.rect_left, e.query.rect_top, e.query.rect_width,
						e.query.rect_height, e.query.seg_start_x, e.query.seg_start_y,
						e.query.seg_end_x, e.query.seg_end_y, e.hit, hit);
			end
		endfunction

		function int outstanding();
			return pending_hits.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic rx_hold_off;
	int tx_idle_pct;
	int rx_idle_pct;
	event long_hold_ev;
	hit_scoreboard sb = new();

	srht_req_if #(.COORD_BITS(CB)) req ();
	srht_rsp_if rsp ();

	segment_rect_hit_test_unit #(.COORD_BITS(CB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (rx_hold_off || $urandom_range(99) < rx_idle_pct)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= 1'b1;
	end

	// One long receiver stall, so the pipeline fills and pushes back on req.
	initial begin
		rx_hold_off = 1'b0;
		@(long_hold_ev);
		rx_hold_off <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		rx_hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
			sb.check_hit(rsp.hit);
	end

	initial begin
		#(LIMIT_NS);
		$display("== FAIL ==");
		$finish;
	end

	function automatic int clamp_coord(int v);
		if (v < MIN_COORD)
			return MIN_COORD;
		if (v > MAX_COORD)
			return MAX_COORD;
		return v;
	endfunction

	function automatic int pick(int lo, int hi);
		return clamp_coord(lo + int'($urandom_range(0, hi - lo)));
	endfunction

	function automatic hit_query_t make_query(int l, int t, int w, int h,
			int sx, int sy, int ex, int ey);
		hit_query_t q;
		q.rect_left = CB'(l);
		q.rect_top = CB'(t);
		q.rect_width = (CB-1)'(w);
		q.rect_height = (CB-1)'(h);
		q.seg_start_x = CB'(sx);
		q.seg_start_y = CB'(sy);
		q.seg_end_x = CB'(ex);
		q.seg_end_y = CB'(ey);
		return q;
	endfunction

	function automatic hit_query_t random_query();
		int kind, w, h, l, t, r, b, m, sx, sy, ex, ey;
		kind = $urandom_range(99);
		if (kind < 12)
			return make_query($urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom);
		// Mostly small rectangles; only a few span the whole range.
		w = (kind >= 90) ? $urandom_range(0, MAX_SIZE) : $urandom_range(0, 300);
		h = (kind >= 90) ? $urandom_range(0, MAX_SIZE) : $urandom_range(0, 300);
		if (kind >= 82 && kind < 90 && $urandom_range(1) == 0) begin
			if ($urandom_range(1) == 0)
				w = 0;
			else
				h = 0;
		end
		l = pick(MIN_COORD, MAX_COORD - w);
		t = pick(MIN_COORD, MAX_COORD - h);
		r = l + w;
		b = t + h;
		m = w / 2 + h / 2 + 20;
		sx = pick(l - m, r + m);
		sy = pick(t - m, b + m);
		ex = pick(l - m, r + m);
		ey = pick(t - m, b + m);
		if (kind >= 90) begin
			sx = pick(MIN_COORD, MAX_COORD);
			sy = pick(MIN_COORD, MAX_COORD);
			ex = pick(MIN_COORD, MAX_COORD);
			ey = pick(MIN_COORD, MAX_COORD);
		end else if (kind >= 60 && kind < 72) begin
			// Put one endpoint exactly on an edge.
			case ($urandom_range(3))
				0: begin sx = l; sy = pick(t, b); end
				1: begin sx = r; sy = pick(t, b); end
				2: begin sy = t; sx = pick(l, r); end
				default: begin sy = b; sx = pick(l, r); end
			endcase
		end else if (kind >= 72 && kind < 82) begin
			if ($urandom_range(1) == 0) begin
				if ($urandom_range(1) == 0)
					sx = ($urandom_range(1) == 0) ? l : r;
				ex = sx;
			end else begin
				if ($urandom_range(1) == 0)
					sy = ($urandom_range(1) == 0) ? t : b;
				ey = sy;
			end
		end else if (kind >= 82 && kind < 90 && $urandom_range(1) == 0) begin
			ex = sx;
			ey = sy;
		end
		return make_query(l, t, w, h, sx, sy, ex, ey);
	endfunction

	task automatic send_query(hit_query_t q);
		while ($urandom_range(99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.rect_left <= q.rect_left;
		req.rect_top <= q.rect_top;
		req.rect_width <= q.rect_width;
		req.rect_height <= q.rect_height;
		req.seg_start_x <= q.seg_start_x;
		req.seg_start_y <= q.seg_start_y;
		req.seg_end_x <= q.seg_end_x;
		req.seg_end_y <= q.seg_end_y;
		req.valid <= 1'b1;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		sb.note_query(q);
	endtask

	task automatic send_random(int count);
		repeat (count) send_query(random_query());
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.rect_left = '0;
		req.rect_top = '0;
		req.rect_width = '0;
		req.rect_height = '0;
		req.seg_start_x = '0;
		req.seg_start_y = '0;
		req.seg_end_x = '0;
		req.seg_end_y = '0;
		rsp.ready = 1'b0;
		tx_idle_pct = 28;
		rx_idle_pct = 88;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_query(make_query(0, 0, 10, 10, -5, 5, 15, 5));
		send_query(make_query(0, 0, 10, 10, 5, -5, 5, 15));
		send_query(make_query(0, 0, 10, 10, 2, 2, 8, 8));
		send_query(make_query(0, 0, 10, 10, 20, 20, 30, 30));
		send_query(make_query(0, 0, 10, 10, -5, 0, 15, 0));
		send_query(make_query(0, 0, 10, 10, 2, 0, 8, 0));
		send_query(make_query(0, 0, 10, 10, -5, 5, 0, 5));
		send_query(make_query(0, 0, 10, 10, -5, -5, 0, 0));
		send_query(make_query(0, 0, 10, 10, 0, 5, 0, 5));
		send_query(make_query(5, 5, 0, 0, 0, 0, 10, 10));
		send_query(make_query(5, 0, 0, 10, 0, 5, 10, 5));
		send_query(make_query(0, 5, 10, 0, 5, 0, 5, 10));
		send_query(make_query(0, 0, 10, 10, -5, 5, -1, 5));
		send_query(make_query(0, 0, 10, 10, 10, -5, 10, 15));
		send_query(make_query(MIN_COORD, MIN_COORD, MAX_SIZE, MAX_SIZE,
			MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD));
		send_query(make_query(MAX_COORD, MAX_COORD, MAX_SIZE, MAX_SIZE,
			MAX_COORD, MIN_COORD, MIN_COORD, MAX_COORD));
		send_query(make_query(MIN_COORD, MIN_COORD, 0, 0,
			MIN_COORD, MAX_COORD, MAX_COORD, MIN_COORD));
		send_query(make_query(0, 0, MAX_SIZE, MAX_SIZE,
			MIN_COORD, MAX_COORD, MAX_COORD, MIN_COORD));
		send_query(make_query(-1, -1, 2, 2, MAX_COORD, MAX_COORD, MIN_COORD, MIN_COORD));
		send_query(make_query(-100, -100, 200, 50, MIN_COORD, -75, MAX_COORD, -75));

		send_random(QUERIES_PER_PHASE);
		wait_drained();

		tx_idle_pct = 88;
		rx_idle_pct = 28;
		send_random(QUERIES_PER_PHASE);
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		-> long_hold_ev;
		send_random(QUERIES_PER_PHASE / 2);
		wait_drained();
		send_random(QUERIES_PER_PHASE / 2);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
